// ===== rtl/core/tspe_pkg.sv =====
// tspe_pkg: shared types and constants of the time source pool election block
// transaction structs, status codes, register indexes, controller/datapath link
// no dependencies
package tspe_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCE  = 4'd1;

    // timing constants
    localparam int                  DEATH_PERIODS = 3;
    localparam int                  THR_W         = 18;
    localparam logic [15:0]         PERIOD_RESET  = 16'd300;
    localparam logic [15:0]         MIN_PERIOD    = 16'd10;
    localparam logic [THR_W-1:0]    THR_RESET     = THR_W'(DEATH_PERIODS * 300);
    localparam logic [31:0]         NTP_TO_UNIX   = 32'd2208988800;
    localparam logic [19:0]         USEC_PER_SEC  = 20'd1000000;
    localparam logic [7:0]          MAX_STRATUM   = 8'd255;

    typedef enum logic [1:0] {
        ST_IGNORED   = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_STORED    = 2'd2,
        ST_TICK_DONE = 2'd3
    } status_t;

    typedef struct packed {
        logic        op;
        logic        gps_active;
        logic [31:0] sender_address;
        logic [7:0]  sender_stratum;
        logic [31:0] transmit_seconds;
        logic [31:0] transmit_fraction;
        logic [31:0] now_seconds;
        logic [19:0] now_usec;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  slot;
        logic        source_valid;
        logic [2:0]  source_slot;
        logic [8:0]  local_stratum_out;
        logic        sync;
        logic [31:0] origin_unix_seconds;
        logic [19:0] origin_usec;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic dispatch;
        logic scan;
        logic place;
        logic elect;
        logic elect_done;
        logic tick_read;
        logic tick_eval;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic is_ignore;
        logic scan_last;
        logic elect_needed;
    } dp_stat_t;

endpackage

// ===== rtl/core/tspe_ctrl.sv =====
// tspe_ctrl: sequencing state machine of the pool election block
// drives datapath commands and the handshake of both channels
// depends on tspe_pkg
module tspe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output tspe_pkg::dp_cmd_t  cmd,
    input  tspe_pkg::dp_stat_t stat
);
    import tspe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_PLACE,
        S_ELECT,
        S_ELECT_DONE,
        S_TICK_RD,
        S_TICK_EVAL,
        S_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = (state_reg == S_IDLE) && in_valid;
        cmd.dispatch   = (state_reg == S_DISPATCH);
        cmd.scan       = (state_reg == S_SCAN);
        cmd.place      = (state_reg == S_PLACE);
        cmd.elect      = (state_reg == S_ELECT);
        cmd.elect_done = (state_reg == S_ELECT_DONE);
        cmd.tick_read  = (state_reg == S_TICK_RD);
        cmd.tick_eval  = (state_reg == S_TICK_EVAL);
        cmd.load_out   = (state_reg == S_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    if (stat.is_tick)
                    begin
                        state_reg <= S_TICK_RD;
                    end
                    else if (stat.is_ignore)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (stat.scan_last)
                    begin
                        state_reg <= S_PLACE;
                    end
                end
                S_PLACE:
                begin
                    if (stat.elect_needed)
                    begin
                        state_reg <= S_ELECT;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_ELECT:
                begin
                    if (stat.scan_last)
                    begin
                        state_reg <= S_ELECT_DONE;
                    end
                end
                S_ELECT_DONE:
                begin
                    state_reg <= S_FINISH;
                end
                S_TICK_RD:
                begin
                    state_reg <= S_TICK_EVAL;
                end
                S_TICK_EVAL:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/tspe_dp.sv =====
// tspe_dp: pool memory, scan registers, election state and result register
// executes the commands of tspe_ctrl, holds the configuration registers
// depends on tspe_pkg
module tspe_dp #(
    parameter int POOL_SIZE = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tspe_pkg::in_item_t                  in_data,
    input  logic                                cfg_write,
    input  logic [tspe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tspe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  tspe_pkg::dp_cmd_t                   cmd,
    output tspe_pkg::dp_stat_t                  stat,
    output tspe_pkg::out_item_t                 out_data
);
    import tspe_pkg::*;

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int CNT_W = $clog2(POOL_SIZE + 1);

    // configuration
    logic [THR_W-1:0]  thr_reg;
    logic              force_reg;
    logic [15:0]       period_clamped;
    logic [THR_W-1:0]  thr_next;

    // current transaction
    in_item_t          item_reg;
    logic [31:0]       lim_reg;
    logic              lim_pos_reg;
    logic [19:0]       usec_reg;
    logic [32:0]       lim_diff;
    logic [51:0]       usec_prod;

    // scan sequencing
    logic [CNT_W-1:0]  cnt_reg;
    logic              eval_vld_reg;
    logic [IDX_W-1:0]  eval_idx_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    // pool memory and per-entry valid bits
    logic [31:0]       addr_mem   [POOL_SIZE];
    logic [31:0]       seen_mem   [POOL_SIZE];
    logic [7:0]        strat_mem  [POOL_SIZE];
    logic [POOL_SIZE-1:0] valid_reg;
    logic [31:0]       rd_address_reg;
    logic [31:0]       rd_seen_reg;
    logic [7:0]        rd_strat_reg;
    logic              rd_valid_reg;

    logic [31:0]       e_addr;
    logic [31:0]       e_seen;
    logic [7:0]        e_strat;
    logic              e_dead;
    logic              e_match;
    logic              eval1;
    logic              eval2;
    logic              clear_we;

    // scan results
    logic [IDX_W-1:0]  sender_reg;
    logic              sender_found_reg;
    logic [IDX_W-1:0]  avail_reg;
    logic              avail_found_reg;
    logic [IDX_W-1:0]  weakest_reg;
    logic              weakest_found_reg;
    logic [7:0]        worst_reg;
    logic [7:0]        src_strat_reg;
    logic [7:0]        best_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [IDX_W-1:0]  slot_reg;

    logic              place_found;
    logic [IDX_W-1:0]  place_idx;
    logic              place_weak;
    logic              have_after;
    logic [IDX_W-1:0]  src_cand;
    logic [8:0]        strat_plus1;
    logic              tick_keep;

    // election state
    logic              have_source_reg;
    logic [IDX_W-1:0]  source_index_reg;
    logic [8:0]        local_stratum_reg;
    logic              have_source_next;
    logic [IDX_W-1:0]  source_index_next;
    logic [8:0]        local_stratum_next;

    // result
    status_t           status_reg;
    logic              sync_reg;
    out_item_t         out_reg;
    logic              stored;
    logic [IDX_W+2:0]  slot_ext;
    logic [IDX_W+2:0]  src_ext;

    // configuration registers
    assign period_clamped = (cfg_data < MIN_PERIOD) ? MIN_PERIOD : cfg_data;
    assign thr_next       = THR_W'(period_clamped) * THR_W'(DEATH_PERIODS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            force_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PERIOD: thr_reg   <= thr_next;
                CFG_FORCE:  force_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // decode and per-transaction precomputation
    assign lim_diff  = {1'b0, item_reg.now_seconds} - 33'(thr_reg);
    assign usec_prod = item_reg.transmit_fraction * USEC_PER_SEC;

    assign stat.is_tick      = item_reg.op;
    assign stat.is_ignore    = !item_reg.op &&
                               ((item_reg.sender_stratum == 8'd0) || item_reg.gps_active);
    assign stat.scan_last    = (cnt_reg == CNT_W'(POOL_SIZE));
    assign stat.elect_needed = place_found && !have_after;

    // memory read port
    assign rd_en   = cmd.tick_read ||
                     ((cmd.scan || cmd.elect) && (cnt_reg < CNT_W'(POOL_SIZE)));
    assign rd_addr = cmd.tick_read ? source_index_reg : cnt_reg[IDX_W-1:0];

    // never-written entries read as zero
    assign e_addr  = rd_valid_reg ? rd_address_reg : 32'd0;
    assign e_seen  = rd_valid_reg ? rd_seen_reg    : 32'd0;
    assign e_strat = rd_valid_reg ? rd_strat_reg   : 8'd0;
    assign e_dead  = lim_pos_reg && (e_seen < lim_reg);
    assign e_match = (e_addr == item_reg.sender_address);
    assign eval1   = cmd.scan && eval_vld_reg;
    assign eval2   = cmd.elect && eval_vld_reg;
    assign clear_we = eval1 && !e_match && e_dead;

    always_ff @(posedge clk)
    begin
        if (cmd.place && place_found)
        begin
            addr_mem[place_idx]  <= item_reg.sender_address;
            seen_mem[place_idx]  <= item_reg.now_seconds;
            strat_mem[place_idx] <= item_reg.sender_stratum;
        end
        else if (clear_we)
        begin
            strat_mem[eval_idx_reg] <= 8'd0;
        end
        if (rd_en)
        begin
            rd_address_reg <= addr_mem[rd_addr];
            rd_seen_reg    <= seen_mem[rd_addr];
            rd_strat_reg   <= strat_mem[rd_addr];
            rd_valid_reg   <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.place && place_found)
        begin
            valid_reg[place_idx] <= 1'b1;
        end
    end

    // slot selection after the first pass
    assign place_weak  = !sender_found_reg && !avail_found_reg && weakest_found_reg;
    assign place_found = sender_found_reg || avail_found_reg || weakest_found_reg;
    assign place_idx   = sender_found_reg ? sender_reg :
                         avail_found_reg  ? avail_reg  : weakest_reg;
    assign have_after  = have_source_reg &&
                         !(place_weak && (source_index_reg == weakest_reg));
    assign src_cand    = ((place_idx != source_index_reg) &&
                          (item_reg.sender_stratum < src_strat_reg)) ?
                         place_idx : source_index_reg;
    assign strat_plus1 = {1'b0, item_reg.sender_stratum} + 9'd1;
    assign tick_keep   = have_source_reg && !e_dead;

    // election state update
    always_comb
    begin
        have_source_next   = have_source_reg;
        source_index_next  = source_index_reg;
        local_stratum_next = local_stratum_reg;
        if (clear_we && (source_index_reg == eval_idx_reg))
        begin
            have_source_next = 1'b0;
        end
        if (cmd.place && place_found)
        begin
            have_source_next = have_after;
            if (have_after)
            begin
                source_index_next = src_cand;
                if (place_idx == src_cand)
                begin
                    local_stratum_next = strat_plus1;
                end
            end
        end
        if (cmd.elect_done)
        begin
            have_source_next  = 1'b1;
            source_index_next = pick_reg;
            if (pick_reg == slot_reg)
            begin
                local_stratum_next = strat_plus1;
            end
        end
        if (cmd.tick_eval)
        begin
            if (force_reg || item_reg.gps_active)
            begin
                have_source_next = 1'b0;
            end
            else
            begin
                have_source_next = tick_keep;
                if (!tick_keep)
                begin
                    local_stratum_next = 9'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_source_reg   <= 1'b0;
            source_index_reg  <= '0;
            local_stratum_reg <= 9'd0;
            cnt_reg           <= '0;
            eval_vld_reg      <= 1'b0;
        end
        else
        begin
            have_source_reg   <= have_source_next;
            source_index_reg  <= source_index_next;
            local_stratum_reg <= local_stratum_next;
            if (cmd.dispatch || cmd.place)
            begin
                cnt_reg      <= '0;
                eval_vld_reg <= 1'b0;
            end
            else if (cmd.scan || cmd.elect)
            begin
                eval_vld_reg <= rd_en;
                if (rd_en)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // slot numbers wrap to three bits
    assign stored   = (status_reg == ST_STORED);
    assign slot_ext = {3'b000, slot_reg};
    assign src_ext  = {3'b000, source_index_reg};

    function automatic out_item_t out_next();
        out_item_t o;
        o.status              = status_reg;
        o.slot                = stored ? slot_ext[2:0] : 3'd0;
        o.source_valid        = have_source_reg;
        o.source_slot         = src_ext[2:0];
        o.local_stratum_out   = local_stratum_reg;
        o.sync                = sync_reg;
        o.origin_unix_seconds = stored ? (item_reg.transmit_seconds - NTP_TO_UNIX) : 32'd0;
        o.origin_usec         = stored ? usec_reg : 20'd0;
        return o;
    endfunction

    // transaction, scan and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_data;
        end
        if ((cmd.scan || cmd.elect) && rd_en)
        begin
            eval_idx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (cmd.dispatch)
        begin
            lim_reg           <= lim_diff[31:0];
            lim_pos_reg       <= !lim_diff[32];
            usec_reg          <= usec_prod[51:32];
            sender_found_reg  <= 1'b0;
            avail_found_reg   <= 1'b0;
            weakest_found_reg <= 1'b0;
            worst_reg         <= item_reg.sender_stratum;
            sync_reg          <= 1'b0;
            status_reg        <= item_reg.op ? ST_TICK_DONE : ST_IGNORED;
        end
        if (eval1)
        begin
            if (eval_idx_reg == source_index_reg)
            begin
                src_strat_reg <= e_strat;
            end
            if (e_match)
            begin
                sender_reg       <= eval_idx_reg;
                sender_found_reg <= 1'b1;
            end
            else if (e_dead)
            begin
                if (!avail_found_reg)
                begin
                    avail_reg       <= eval_idx_reg;
                    avail_found_reg <= 1'b1;
                end
            end
            else if (e_strat > worst_reg)
            begin
                weakest_reg       <= eval_idx_reg;
                weakest_found_reg <= 1'b1;
                worst_reg         <= e_strat;
            end
        end
        if (cmd.place)
        begin
            status_reg <= place_found ? ST_STORED : ST_DROPPED;
            slot_reg   <= place_idx;
            pick_reg   <= place_idx;
            best_reg   <= MAX_STRATUM;
            if (place_found && have_after && (place_idx == src_cand))
            begin
                sync_reg <= 1'b1;
            end
        end
        if (eval2 && !e_dead && (e_strat != 8'd0) && (e_strat < best_reg))
        begin
            pick_reg <= eval_idx_reg;
            best_reg <= e_strat;
        end
        if (cmd.elect_done && (pick_reg == slot_reg))
        begin
            sync_reg <= 1'b1;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next();
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/core/time_source_pool_election_top.sv =====
// time_source_pool_election_top: top level of the time source pool election block
// joins the sequencing controller and the pool datapath
// depends on tspe_pkg, tspe_ctrl, tspe_dp
//
// usage
// - input channel in_valid/in_ready/in_data carries one broadcast or tick per transaction
// - output channel out_valid/out_ready/out_data returns exactly one result per input
// - cfg_write/cfg_index/cfg_data write period (index 0) or server mode (index 1),
//   only while the block is idle; other indexes are ignored
// - one item at a time: in_ready is high only while no item is being worked on
// - broadcast: decode, a first pass over the pool, placement, and, when the broadcast is
//   stored and no source is held after it, an election pass, then the result is posted;
//   both passes read the pool through its single read port
// - tick: decode, read of the source entry, evaluation, post; ignored broadcast: decode, post;
//   the block passes through idle before the next accept
// - the result register frees the input side: a new item is taken while a result waits,
//   but its own result is posted only once the previous one has been taken
// - reset empties the pool (per-entry valid bits), drops the source, zeroes the local
//   stratum and loads period 300 s and client mode; no clearing pass is needed
module time_source_pool_election_top #(
    parameter int POOL_SIZE = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tspe_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tspe_pkg::out_item_t                 out_data,
    input  logic                                cfg_write,
    input  logic [tspe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tspe_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tspe_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: owns in_ready and out_valid
    tspe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // pool memory, election state, config registers and result register
    tspe_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // one item in flight: acceptance closes the input side
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // origin fields only carry data for a stored broadcast
    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_STORED) |->
            (out_data.origin_unix_seconds == 32'd0) && (out_data.origin_usec == 20'd0)
            && (out_data.slot == 3'd0))
        else $error("origin or slot set on a result that stored nothing");

    // a sync comes only from a stored broadcast of the elected source
    a_sync_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sync |->
            out_data.source_valid && (out_data.status == ST_STORED)
            && (out_data.slot == out_data.source_slot)
            && (out_data.local_stratum_out != 9'd0))
        else $error("sync without a matching elected source");
`endif

endmodule
